// ===== rtl/blg_pkg.sv =====
package blg_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int WINDOW_DEPTH = 16;
  localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);
  localparam int SUM_BITS     = SAMPLE_BITS + SLOT_BITS;
  localparam int ALU_BITS     = SUM_BITS + 1;
  localparam int MV_BITS      = 13;
  localparam int PCT_BITS     = 7;
  localparam int LEVEL_POINTS = 11;
  localparam int IDX_BITS     = 4;
  localparam int SPAN_BITS    = 8;
  localparam int NUM_BITS     = 12;
  localparam int QUO_BITS     = 4;
  localparam int PROD_BITS    = SAMPLE_BITS + MV_BITS;

  localparam logic [MV_BITS-1:0]  MV_SCALE  = 13'd6600;
  localparam logic [PCT_BITS-1:0] PCT_EMPTY = 7'd0;
  localparam logic [PCT_BITS-1:0] PCT_FULL  = 7'd100;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] filtered_sample;
    logic [MV_BITS-1:0]     battery_mv;
    logic [PCT_BITS-1:0]    charge_percent;
  } blg_res_t;

  typedef struct packed {
    logic [ALU_BITS-1:0] a;
    logic [ALU_BITS-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_BITS-1:0] diff;
    logic                borrow;
  } alu_rsp_t;

  function automatic logic [MV_BITS-1:0] level_mv(input logic [IDX_BITS-1:0] idx);
    logic [MV_BITS-1:0] v;
    case (idx)
      4'd0:    v = 13'd3400;
      4'd1:    v = 13'd3650;
      4'd2:    v = 13'd3700;
      4'd3:    v = 13'd3740;
      4'd4:    v = 13'd3760;
      4'd5:    v = 13'd3795;
      4'd6:    v = 13'd3840;
      4'd7:    v = 13'd3910;
      4'd8:    v = 13'd3980;
      4'd9:    v = 13'd4070;
      default: v = 13'd4200;
    endcase
    return v;
  endfunction

  function automatic logic [SPAN_BITS-1:0] level_span(input logic [IDX_BITS-1:0] idx);
    logic [SPAN_BITS-1:0] s;
    case (idx)
      4'd1:    s = 8'd250;
      4'd2:    s = 8'd50;
      4'd3:    s = 8'd40;
      4'd4:    s = 8'd20;
      4'd5:    s = 8'd35;
      4'd6:    s = 8'd45;
      4'd7:    s = 8'd70;
      4'd8:    s = 8'd70;
      4'd9:    s = 8'd90;
      4'd10:   s = 8'd130;
      default: s = 8'd1;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/battery_level_gauge.sv =====
// The delay from an accepted input beat to out_tvalid is set by the walk over
// the 11-point level table and the 4-step restoring divide that share one
// subtractor; below 3400 mV or at 4200 mV and above, no divide runs.
// The core takes a new beat only when idle, once its last result has moved
// on; a result held in the output register stalls only the following result.
// Reset: synchronous, active low; clears the sample ring, sum and slot to zero.
module battery_level_gauge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] raw_sample, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [11:0] filtered_sample, [24:12] battery_mv,
                                  // [31:25] charge_percent
);

  logic              out_valid_r;
  blg_pkg::blg_res_t out_data_r;
  logic              res_valid;
  logic              res_take;
  blg_pkg::blg_res_t res;

  blg_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sample   (in_tdata[blg_pkg::SAMPLE_BITS-1:0]),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.charge_percent, out_data_r.battery_mv,
                       out_data_r.filtered_sample};

endmodule

// ===== rtl/blg_alu.sv =====
module blg_alu (
  input  blg_pkg::alu_req_t req,
  output blg_pkg::alu_rsp_t rsp
);

  logic [blg_pkg::ALU_BITS:0] full;

  assign full       = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff   = full[blg_pkg::ALU_BITS-1:0];
  assign rsp.borrow = full[blg_pkg::ALU_BITS];

endmodule

// ===== rtl/blg_core.sv =====
module blg_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [blg_pkg::SAMPLE_BITS-1:0] sample,
  output logic                            res_valid,
  input  logic                            res_take,
  output blg_pkg::blg_res_t               res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam logic [blg_pkg::IDX_BITS-1:0] IDX_LAST =
    blg_pkg::IDX_BITS'(blg_pkg::LEVEL_POINTS - 1);

  logic [2:0] state_r, state_nxt;

  logic [blg_pkg::SAMPLE_BITS-1:0] ring_r [blg_pkg::WINDOW_DEPTH];
  logic [blg_pkg::SLOT_BITS-1:0]   slot_r;
  logic [blg_pkg::SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [blg_pkg::SAMPLE_BITS-1:0] sample_r;
  logic [blg_pkg::SAMPLE_BITS-1:0] oldest_r;
  logic [blg_pkg::SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [blg_pkg::MV_BITS-1:0]     mv_r, mv_nxt;
  logic [blg_pkg::IDX_BITS-1:0]    idx_r, idx_nxt;
  logic [blg_pkg::NUM_BITS-1:0]    rem_r, rem_nxt;
  logic [blg_pkg::SPAN_BITS-1:0]   span_r, span_nxt;
  logic [blg_pkg::QUO_BITS-1:0]    quo_r, quo_nxt;
  logic [1:0]                      bit_r, bit_nxt;
  logic [blg_pkg::PCT_BITS-1:0]    pct_r, pct_nxt;

  logic                            accept;
  logic [blg_pkg::PROD_BITS-1:0]   prod;
  logic [blg_pkg::SPAN_BITS-1:0]   gap;
  logic [blg_pkg::NUM_BITS-1:0]    gap_ext;
  logic [blg_pkg::PCT_BITS-1:0]    idx_ext;
  blg_pkg::alu_req_t               alu_req;
  blg_pkg::alu_rsp_t               alu_rsp;

  blg_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign prod     = blg_pkg::PROD_BITS'(avg_r) * blg_pkg::PROD_BITS'(blg_pkg::MV_SCALE);
  assign gap      = alu_rsp.diff[blg_pkg::SPAN_BITS-1:0];
  assign gap_ext  = blg_pkg::NUM_BITS'(gap);
  assign idx_ext  = blg_pkg::PCT_BITS'(idx_r);

  always_comb begin
    alu_req = '0;
    unique case (state_r)
      ST_SUM: begin
        alu_req.a = blg_pkg::ALU_BITS'(sum_r) + blg_pkg::ALU_BITS'(sample_r);
        alu_req.b = blg_pkg::ALU_BITS'(oldest_r);
      end
      ST_SRCH: begin
        alu_req.a = blg_pkg::ALU_BITS'(mv_r);
        alu_req.b = blg_pkg::ALU_BITS'(blg_pkg::level_mv(idx_r));
      end
      ST_PREP: begin
        alu_req.a = blg_pkg::ALU_BITS'(blg_pkg::level_mv(idx_r));
        alu_req.b = blg_pkg::ALU_BITS'(mv_r);
      end
      ST_DIV: begin
        alu_req.a = blg_pkg::ALU_BITS'(rem_r);
        alu_req.b = blg_pkg::ALU_BITS'(span_r) << bit_r;
      end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    avg_nxt   = avg_r;
    mv_nxt    = mv_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    span_nxt  = span_r;
    quo_nxt   = quo_r;
    bit_nxt   = bit_r;
    pct_nxt   = pct_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt   = alu_rsp.diff[blg_pkg::SUM_BITS-1:0];
        avg_nxt   = sum_nxt[blg_pkg::SUM_BITS-1:blg_pkg::SLOT_BITS];
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mv_nxt    = prod[blg_pkg::PROD_BITS-1:blg_pkg::SAMPLE_BITS];
        idx_nxt   = '0;
        state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        if (alu_rsp.borrow) begin
          if (idx_r == '0) begin
            pct_nxt   = blg_pkg::PCT_EMPTY;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_PREP;
          end
        end else if (idx_r == IDX_LAST) begin
          pct_nxt   = blg_pkg::PCT_FULL;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_PREP: begin
        rem_nxt   = (gap_ext << 3) + (gap_ext << 1);
        span_nxt  = blg_pkg::level_span(idx_r);
        quo_nxt   = '0;
        bit_nxt   = 2'd3;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!alu_rsp.borrow) begin
          rem_nxt        = alu_rsp.diff[blg_pkg::NUM_BITS-1:0];
          quo_nxt[bit_r] = 1'b1;
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == 2'd0) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        pct_nxt   = (idx_ext << 3) + (idx_ext << 1) - blg_pkg::PCT_BITS'(quo_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      sum_r   <= '0;
      for (int i = 0; i < blg_pkg::WINDOW_DEPTH; i++) ring_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      if (accept) begin
        ring_r[slot_r] <= sample;
        slot_r         <= slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample;
      oldest_r <= ring_r[slot_r];
    end
    avg_r  <= avg_nxt;
    mv_r   <= mv_nxt;
    idx_r  <= idx_nxt;
    rem_r  <= rem_nxt;
    span_r <= span_nxt;
    quo_r  <= quo_nxt;
    bit_r  <= bit_nxt;
    pct_r  <= pct_nxt;
  end

  assign res_valid           = (state_r == ST_DONE);
  assign res.filtered_sample = avg_r;
  assign res.battery_mv      = mv_r;
  assign res.charge_percent  = pct_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SUM)
    else $error("accepted sample did not start the sum step");

  a_div_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> span_r != '0 && idx_r != '0)
    else $error("divide running without a table segment");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> pct_r <= blg_pkg::PCT_FULL)
    else $error("charge percentage out of range");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("finished result changed before it was taken");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready)
    else $error("ready raised while busy");

endmodule

// ===== tb/tb.sv =====
module tb;
  import blg_pkg::*;

  localparam int ITEM_TARGET = 550;
  localparam int PAUSE_AT    = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 2000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = 16'd0;  // [11:0] raw_sample, [15:12] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [11:0] filtered_sample, [24:12] battery_mv,
                                    // [31:25] charge_percent

  battery_level_gauge uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  logic [SAMPLE_BITS-1:0] sample_queue[$];
  blg_res_t               results_due[$];

  logic [SAMPLE_BITS-1:0] win_samples[WINDOW_DEPTH];
  logic [SLOT_BITS-1:0]   win_slot;
  logic [SUM_BITS-1:0]    win_sum;

  int beats_issued = 0;
  int beats_taken  = 0;
  int out_beats    = 0;
  int out_seen     = 0;
  int fail_count   = 0;
  int cycle_count  = 0;
  int in_gap       = 0;
  int in_burst     = 0;
  int out_stall    = 0;
  int out_burst    = 0;
  int n_empty      = 0;
  int n_full       = 0;
  int n_between    = 0;
  bit paused       = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [PCT_BITS-1:0] charge_of(input logic [MV_BITS-1:0] mv);
    int points[LEVEL_POINTS];
    int span;
    points = '{3400, 3650, 3700, 3740, 3760, 3795, 3840, 3910, 3980, 4070, 4200};
    if (mv < points[0]) return PCT_EMPTY;
    for (int i = 1; i < LEVEL_POINTS; i++) begin
      if (mv < points[i]) begin
        span = points[i] - points[i-1];
        return PCT_BITS'(i * 10 - (10 * (points[i] - int'(mv))) / span);
      end
    end
    return PCT_FULL;
  endfunction

  function automatic blg_res_t gauge_step(input logic [SAMPLE_BITS-1:0] sample);
    blg_res_t               r;
    logic [PROD_BITS-1:0]   prod;
    logic [SAMPLE_BITS-1:0] avg;
    win_sum = win_sum + SUM_BITS'(sample) - SUM_BITS'(win_samples[win_slot]);
    win_samples[win_slot] = sample;
    win_slot = win_slot + 1'b1;
    avg  = SAMPLE_BITS'(win_sum >> SLOT_BITS);
    prod = PROD_BITS'(avg) * PROD_BITS'(MV_SCALE);
    r.filtered_sample = avg;
    r.battery_mv      = MV_BITS'(prod >> SAMPLE_BITS);
    r.charge_percent  = charge_of(r.battery_mv);
    return r;
  endfunction

  task automatic add_level_run();
    int mv_t, avg_t, spread, len, v;
    mv_t   = $urandom_range(3350, 4260);
    avg_t  = (mv_t * 4096 + 6599) / 6600;
    spread = $urandom_range(0, 6);
    len    = $urandom_range(10, 24);
    for (int k = 0; k < len; k++) begin
      v = avg_t + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      sample_queue.push_back(SAMPLE_BITS'(v));
    end
  endtask

  task automatic fill_stimulus();
    int len;
    logic [SAMPLE_BITS-1:0] fixed;
    sample_queue.push_back(12'd0);
    sample_queue.push_back(12'd4095);
    sample_queue.push_back(12'hAAA);
    sample_queue.push_back(12'h555);
    repeat (16) sample_queue.push_back(12'd4095);
    repeat (5) sample_queue.push_back(12'd0);
    while (sample_queue.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 8);
          repeat (len) sample_queue.push_back(SAMPLE_BITS'($urandom));
        end
        1: begin
          fixed = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          len   = $urandom_range(16, 20);
          repeat (len) sample_queue.push_back(fixed);
        end
        default: add_level_run();
      endcase
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : watch_beats
    blg_res_t               exp_r;
    logic [SAMPLE_BITS-1:0] got_avg;
    logic [MV_BITS-1:0]     got_mv;
    logic [PCT_BITS-1:0]    got_pct;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_beats++;
        got_avg = out_tdata[11:0];
        got_mv  = out_tdata[24:12];
        got_pct = out_tdata[31:25];
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          exp_r = results_due.pop_front();
          if (got_avg !== exp_r.filtered_sample) begin
            $display("%0t: filtered_sample expected %0d actual %0d",
                     $time, exp_r.filtered_sample, got_avg);
            fail_count++;
          end
          if (got_mv !== exp_r.battery_mv) begin
            $display("%0t: battery_mv expected %0d actual %0d",
                     $time, exp_r.battery_mv, got_mv);
            fail_count++;
          end
          if (got_pct !== exp_r.charge_percent) begin
            $display("%0t: charge_percent expected %0d actual %0d",
                     $time, exp_r.charge_percent, got_pct);
            fail_count++;
          end
          if (exp_r.charge_percent == PCT_EMPTY) n_empty++;
          else if (exp_r.charge_percent == PCT_FULL) n_full++;
          else n_between++;
        end
      end
      if (in_tvalid && in_tready) begin
        beats_taken++;
        results_due.push_back(gauge_step(in_tdata[SAMPLE_BITS-1:0]));
      end
    end
  end

  always @(negedge clk) begin : drive_in
    logic        next_valid;
    logic [15:0] next_data;
    bit          hold;
    if (rst_n) begin
      next_valid = in_tvalid;
      next_data  = in_tdata;
      if (in_tvalid && beats_taken == beats_issued) next_valid = 1'b0;
      if (!next_valid) begin
        hold = (beats_issued == PAUSE_AT) && (results_due.size() != 0);
        if (beats_issued == PAUSE_AT) paused = 1'b1;
        if (in_gap > 0) begin
          in_gap--;
        end else if (sample_queue.size() > 0 && !hold) begin
          next_data  = {4'd0, sample_queue.pop_front()};
          next_valid = 1'b1;
          beats_issued++;
          if (in_burst > 0) begin
            in_burst--;
            in_gap = 0;
          end else begin
            in_gap = $urandom_range(0, 4);
            if ($urandom_range(0, 19) == 0) in_burst = $urandom_range(10, 40);
          end
        end
      end
      in_tvalid <= next_valid;
      in_tdata  <= next_data;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_beats != out_seen) begin
        out_seen = out_beats;
        if (out_burst > 0) begin
          out_burst--;
          out_stall = 0;
        end else begin
          out_stall = $urandom_range(0, 4);
          if ($urandom_range(0, 19) == 0) out_burst = $urandom_range(10, 40);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : run_gauge
    int drain;
    for (int k = 0; k < WINDOW_DEPTH; k++) win_samples[k] = '0;
    win_slot = '0;
    win_sum  = '0;
    fill_stimulus();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (sample_queue.size() != 0 || beats_taken != beats_issued) @(posedge clk);
    drain = 0;
    while (results_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      fail_count++;
    end
    $display("Sent %0d samples, checked %0d results, held once for a full drain: %0d",
             beats_issued, out_beats, paused);
    $display("Charge results: %0d empty, %0d full, %0d interpolated; %0d failures",
             n_empty, n_full, n_between, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
